// ===== design/assert_macros.svh =====
// Assertion macros shared by the block pool allocator modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define BPA_ASSERT_CR(label, ck, rn, prop) \
    label: assert property (@(posedge ck) disable iff (!rn) prop) \
        else $error("assertion failed");
`define BPA_ASSERT(label, prop) `BPA_ASSERT_CR(label, clk, rst_n, prop)
`else
`define BPA_ASSERT_CR(label, ck, rn, prop)
`define BPA_ASSERT(label, prop)
`endif
`endif

// ===== design/bpa_pkg.sv =====
// ----------------------------------------------------------------------------
// bpa_pkg
// Types and constants of the block pool allocator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package bpa_pkg;

    localparam int POOL_BLOCKS   = 64;
    localparam int REQUEST_SLOTS = 16;
    localparam int BLK_W         = $clog2(POOL_BLOCKS);
    localparam int CNT_W         = 7;
    localparam int SLOT_W        = $clog2(REQUEST_SLOTS);
    localparam int LIST_AW       = SLOT_W + BLK_W;

    localparam logic [1:0] KIND_ALLOC = 2'd0;
    localparam logic [1:0] KIND_FREE  = 2'd1;

    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_INSUF   = 2'd1;
    localparam logic [1:0] STATUS_UNKNOWN = 2'd2;

    typedef struct packed {
        logic [1:0] kind;
        logic [3:0] request;
        logic [6:0] count;
    } in_item_t;

    typedef struct packed {
        logic [1:0] status;
        logic       block_valid;
        logic [5:0] block;
        logic       last;
        logic [6:0] free_cnt;
        logic [6:0] used_cnt;
        logic [6:0] max_run;
    } out_item_t;

    typedef enum logic [1:0] {
        OP_ALLOC,
        OP_FREE,
        OP_STATS
    } op_t;

    typedef struct packed {
        op_t               op;
        logic [SLOT_W-1:0] slot;
        logic [CNT_W-1:0]  count;
    } cmd_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_POP_RD,
        ST_POP_WR,
        ST_EM_RD,
        ST_EM_OUT,
        ST_FR_RD,
        ST_FR_WR,
        ST_SCAN,
        ST_DONE
    } st_t;

endpackage

// ===== design/block_pool_allocator.sv =====
// ----------------------------------------------------------------------------
// block_pool_allocator
// Pool of fixed blocks with LIFO free stack, used bitmap and per-slot lists.
// ----------------------------------------------------------------------------
// Sequence (back end): an allocate pops its blocks from the free stack into the
//   slot's list, then walks the list and strobes one result per listed block;
//   a free walks the list back onto the stack; stats scans the used bitmap. The
//   queue takes up to two new commands while the back end is busy; the back-end
//   sequencer and the single read port of the list RAM pace each walk.
// Reset: asynchronous, active low; all blocks free, all slots absent; results
//   are strobed for one cycle and the receiver cannot stall.
`timescale 1ns / 1ps
module block_pool_allocator import bpa_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    output logic      busy,
    input  in_item_t  cmd,
    output logic      strobe,
    output out_item_t result
);

    // Front classifies each transaction and queues it; the back executes.
    logic push, full, avail, pop;
    cmd_t q_wdata, q_rdata;

    bpa_front u_front (
        .start (start),
        .full  (full),
        .cmd   (cmd),
        .busy  (busy),
        .push  (push),
        .entry (q_wdata)
    );

    // Hold up to two commands while the back walks lists or the bitmap.
    bpa_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (q_wdata),
        .pop   (pop),
        .full  (full),
        .avail (avail),
        .rdata (q_rdata)
    );

    bpa_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .avail  (avail),
        .entry  (q_rdata),
        .pop    (pop),
        .strobe (strobe),
        .result (result)
    );

endmodule

// ===== design/bpa_ram.sv =====
// ----------------------------------------------------------------------------
// bpa_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module bpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== design/bpa_front.sv =====
// ----------------------------------------------------------------------------
// bpa_front
// Accept transactions and classify them into queued commands.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module bpa_front import bpa_pkg::*; (
    input  logic     start,
    input  logic     full,
    input  in_item_t cmd,
    output logic     busy,
    output logic     push,
    output cmd_t     entry
);

    always_comb
    begin
        busy = full;
        push = start && !full;
        // wrap the request number onto the slots; kinds 2 and 3 read statistics
        entry.slot  = cmd.request[SLOT_W-1:0];
        entry.count = cmd.count;
        unique case (cmd.kind)
            KIND_ALLOC: entry.op = OP_ALLOC;
            KIND_FREE:  entry.op = OP_FREE;
            default:    entry.op = OP_STATS;
        endcase
    end

endmodule

// ===== design/bpa_queue.sv =====
// ----------------------------------------------------------------------------
// bpa_queue
// Two-entry command queue between front and back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"
module bpa_queue import bpa_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t wdata,
    input  logic pop,
    output logic full,
    output logic avail,
    output cmd_t rdata
);

    cmd_t       mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;

    always_comb
    begin
        full        = (cnt_reg == 2'd2);
        avail       = (cnt_reg != 2'd0);
        rdata       = mem_reg[rd_ptr_reg];
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

    `BPA_ASSERT(a_no_overrun, push |-> !full)
    `BPA_ASSERT(a_no_underrun, pop |-> avail)

endmodule

// ===== design/bpa_back.sv =====
// ----------------------------------------------------------------------------
// bpa_back
// Execute allocate, free and statistics commands against the pool.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"
module bpa_back import bpa_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      avail,
    input  cmd_t      entry,
    output logic      pop,
    output logic      strobe,
    output out_item_t result
);

    st_t               state_reg, state_next;
    op_t               op_reg, op_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic [CNT_W-1:0]  len_reg, len_next;
    logic [CNT_W-1:0]  top_reg, top_next;
    logic [CNT_W-1:0]  cur_reg, cur_next;
    logic [CNT_W-1:0]  best_reg, best_next;
    logic [1:0]        status_reg, status_next;
    logic [POOL_BLOCKS-1:0]   used_reg, used_next;
    logic [POOL_BLOCKS-1:0]   svld_reg, svld_next;
    logic [REQUEST_SLOTS-1:0] pres_reg, pres_next;
    logic [CNT_W-1:0]  slen_reg [REQUEST_SLOTS];
    logic [CNT_W-1:0]  slen_next [REQUEST_SLOTS];
    logic [BLK_W-1:0]  rd_addr_reg, rd_addr_next;
    logic              rd_vld_reg, rd_vld_next;

    logic               stk_we;
    logic [BLK_W-1:0]   stk_waddr, stk_raddr, stk_rdata, stk_wdata;
    logic               lst_we;
    logic [LIST_AW-1:0] lst_waddr, lst_raddr;
    logic [BLK_W-1:0]   lst_wdata, lst_rdata;
    logic [BLK_W-1:0]   pop_blk;
    logic               em_last;

    bpa_ram #(.WIDTH(BLK_W), .DEPTH(POOL_BLOCKS)) u_stack (
        .clk   (clk),
        .we    (stk_we),
        .waddr (stk_waddr),
        .wdata (stk_wdata),
        .raddr (stk_raddr),
        .rdata (stk_rdata)
    );

    bpa_ram #(.WIDTH(BLK_W), .DEPTH(REQUEST_SLOTS * POOL_BLOCKS)) u_lists (
        .clk   (clk),
        .we    (lst_we),
        .waddr (lst_waddr),
        .wdata (lst_wdata),
        .raddr (lst_raddr),
        .rdata (lst_rdata)
    );

    // never-written stack entries read as their reset content
    assign pop_blk = rd_vld_reg ? stk_rdata
                   : BLK_W'(POOL_BLOCKS - 1) - rd_addr_reg;
    assign em_last = (idx_reg + 1'b1 == len_reg);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (avail)
                begin
                    unique case (entry.op)
                        OP_ALLOC:
                        begin
                            if (entry.count > top_reg)
                                state_next = ST_DONE;
                            else if (entry.count != '0)
                                state_next = ST_POP_RD;
                            else if (slen_reg[entry.slot] != '0)
                                state_next = ST_EM_RD;
                            else
                                state_next = ST_DONE;
                        end
                        OP_FREE:
                        begin
                            if (pres_reg[entry.slot] && slen_reg[entry.slot] != '0)
                                state_next = ST_FR_RD;
                            else
                                state_next = ST_DONE;
                        end
                        default: state_next = ST_SCAN;
                    endcase
                end
            end
            ST_POP_RD: state_next = ST_POP_WR;
            ST_POP_WR:
            begin
                if (idx_reg == count_reg)
                    state_next = (len_next != '0) ? ST_EM_RD : ST_DONE;
                else
                    state_next = ST_POP_RD;
            end
            ST_EM_RD:  state_next = ST_EM_OUT;
            ST_EM_OUT: state_next = em_last ? ST_IDLE : ST_EM_RD;
            ST_FR_RD:  state_next = ST_FR_WR;
            ST_FR_WR:  state_next = em_last ? ST_DONE : ST_FR_RD;
            ST_SCAN:
            begin
                if (idx_reg == CNT_W'(POOL_BLOCKS - 1))
                    state_next = ST_DONE;
            end
            ST_DONE:   state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        op_next      = op_reg;
        slot_next    = slot_reg;
        count_next   = count_reg;
        idx_next     = idx_reg;
        len_next     = len_reg;
        top_next     = top_reg;
        cur_next     = cur_reg;
        best_next    = best_reg;
        status_next  = status_reg;
        used_next    = used_reg;
        svld_next    = svld_reg;
        pres_next    = pres_reg;
        slen_next    = slen_reg;
        rd_addr_next = rd_addr_reg;
        rd_vld_next  = rd_vld_reg;
        pop          = 1'b0;
        stk_we       = 1'b0;
        stk_waddr    = top_reg[BLK_W-1:0];
        stk_wdata    = lst_rdata;
        stk_raddr    = BLK_W'(top_reg - 1'b1);
        lst_we       = 1'b0;
        lst_waddr    = {slot_reg, len_reg[BLK_W-1:0]};
        lst_wdata    = pop_blk;
        lst_raddr    = {slot_reg, idx_reg[BLK_W-1:0]};
        strobe       = 1'b0;

        result.status      = status_reg;
        result.block_valid = 1'b0;
        result.block       = '0;
        result.last        = 1'b1;
        result.free_cnt    = top_reg;
        result.used_cnt    = CNT_W'(POOL_BLOCKS) - top_reg;
        result.max_run     = best_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (avail)
                begin
                    pop         = 1'b1;
                    op_next     = entry.op;
                    slot_next   = entry.slot;
                    count_next  = entry.count;
                    idx_next    = '0;
                    cur_next    = '0;
                    best_next   = '0;
                    len_next    = slen_reg[entry.slot];
                    status_next = STATUS_OK;
                    unique case (entry.op)
                        OP_ALLOC:
                        begin
                            if (entry.count > top_reg)
                                status_next = STATUS_INSUF;
                            else
                                pres_next[entry.slot] = 1'b1;
                        end
                        OP_FREE:
                        begin
                            if (!pres_reg[entry.slot])
                                status_next = STATUS_UNKNOWN;
                            else
                            begin
                                // list length is held in len_reg; drop the slot now
                                pres_next[entry.slot] = 1'b0;
                                slen_next[entry.slot] = '0;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_POP_RD:
            begin
                rd_addr_next = stk_raddr;
                rd_vld_next  = svld_reg[stk_raddr];
                top_next     = top_reg - 1'b1;
                idx_next     = idx_reg + 1'b1;
            end
            ST_POP_WR:
            begin
                if (len_reg < CNT_W'(POOL_BLOCKS))
                begin
                    lst_we   = 1'b1;
                    len_next = len_reg + 1'b1;
                end
                used_next[pop_blk] = 1'b1;
                slen_next[slot_reg] = len_next;
                if (idx_reg == count_reg)
                    idx_next = '0;
            end
            ST_EM_RD: ;
            ST_EM_OUT:
            begin
                strobe             = 1'b1;
                result.block_valid = 1'b1;
                result.block       = lst_rdata;
                result.last        = em_last;
                idx_next           = idx_reg + 1'b1;
            end
            ST_FR_RD: ;
            ST_FR_WR:
            begin
                used_next[lst_rdata] = 1'b0;
                if (top_reg < CNT_W'(POOL_BLOCKS))
                begin
                    stk_we               = 1'b1;
                    svld_next[stk_waddr] = 1'b1;
                    top_next             = top_reg + 1'b1;
                end
                idx_next = idx_reg + 1'b1;
            end
            ST_SCAN:
            begin
                if (used_reg[idx_reg[BLK_W-1:0]])
                    cur_next = '0;
                else
                begin
                    cur_next = cur_reg + 1'b1;
                    if (cur_next > best_reg)
                        best_next = cur_next;
                end
                idx_next = idx_reg + 1'b1;
            end
            ST_DONE:
            begin
                strobe = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            top_reg    <= CNT_W'(POOL_BLOCKS);
            used_reg   <= '0;
            svld_reg   <= '0;
            pres_reg   <= '0;
            best_reg   <= '0;
            status_reg <= STATUS_OK;
            for (int i = 0; i < REQUEST_SLOTS; i++)
            begin
                slen_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg  <= state_next;
            top_reg    <= top_next;
            used_reg   <= used_next;
            svld_reg   <= svld_next;
            pres_reg   <= pres_next;
            best_reg   <= best_next;
            status_reg <= status_next;
            slen_reg   <= slen_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        slot_reg    <= slot_next;
        count_reg   <= count_next;
        idx_reg     <= idx_next;
        len_reg     <= len_next;
        cur_reg     <= cur_next;
        rd_addr_reg <= rd_addr_next;
        rd_vld_reg  <= rd_vld_next;
    end

    `BPA_ASSERT(a_top_bound, top_reg <= CNT_W'(POOL_BLOCKS))
    `BPA_ASSERT(a_pop_nonempty, state_reg == ST_POP_RD |-> top_reg != '0)
    `BPA_ASSERT(a_last_ends, strobe && result.last |=> !strobe)
    `BPA_ASSERT(a_stats_only_run, strobe && op_reg != OP_STATS |-> result.max_run == '0)

endmodule
